// ----- src/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 keystream cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  // permutation size and byte width
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned S_DEPTH   = 256;

  // key storage: two 64-bit registers, sixteen byte slots
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned KEY_SLOTS  = 16;
  localparam int unsigned KEY_SLOT_W = 4;
  localparam int unsigned KLEN_W     = 5;
  localparam logic [KLEN_W-1:0] KEY_LEN_RST = 5'd16;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW    = 2'd0,
    CFG_KEY_HIGH   = 2'd1,
    CFG_KEY_LENGTH = 2'd2
  } rc4_cfg_idx_e;

  // input command codes
  typedef enum logic {
    CMD_KEY_SCHED = 1'b0,
    CMD_DATA      = 1'b1
  } rc4_command_e;

  // controller state, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FILL = 6'b000010,
    ST_RD_I = 6'b000100,
    ST_RD_J = 6'b001000,
    ST_WR_I = 6'b010000,
    ST_WR_J = 6'b100000
  } rc4_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic start_ksa;  // clear indices and key slot counter
    logic capture;    // latch data byte and end-of-block mark
    logic ksa;        // current item is a key schedule
    logic fill;       // write identity entry
    logic rd_i;       // read S[i]
    logic rd_j;       // update j, read S[j]
    logic wr_i;       // write S[i], read S[t]
    logic wr_j;       // write S[j]
    logic out_load;   // load the output register
  } rc4_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic i_last;     // index i sits at the last entry
    logic out_busy;   // output register full and stalled
  } rc4_status_t;

endpackage

// ----- src/rc4_ctrl.sv -----
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for the key schedule and the per-byte generator steps.
// ----------------------------------------------------------------------------
module rc4_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 command_i,
  output logic                 in_stall_o,
  input  rc4_pkg::rc4_status_t status_i,
  output rc4_pkg::rc4_cmd_t    cmd_o
);
  import rc4_pkg::*;

  rc4_state_e state_q, state_d;
  logic       ksa_q, ksa_d;
  logic       take;
  logic       data_done;

  // a data byte finishing this cycle frees the input side
  assign data_done  = (state_q == ST_WR_J) && !ksa_q && !status_i.out_busy;
  assign in_stall_o = !((state_q == ST_IDLE) || data_done);
  assign take       = in_valid_i && !in_stall_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    ksa_d   = ksa_q;
    cmd_o   = '0;
    cmd_o.ksa = ksa_q;

    case (state_q)
      ST_IDLE: ;
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (status_i.i_last) begin
          state_d = ST_RD_I;
        end
      end
      ST_RD_I: begin
        cmd_o.rd_i = 1'b1;
        state_d    = ST_RD_J;
      end
      ST_RD_J: begin
        cmd_o.rd_j = 1'b1;
        state_d    = ST_WR_I;
      end
      ST_WR_I: begin
        cmd_o.wr_i = 1'b1;
        state_d    = ST_WR_J;
      end
      ST_WR_J: begin
        cmd_o.wr_j = 1'b1;
        if (ksa_q) begin
          state_d = status_i.i_last ? ST_IDLE : ST_RD_I;
        end else if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // new request from idle or straight after a finished byte
    if (take) begin
      cmd_o.capture = 1'b1;
      if (command_i == CMD_KEY_SCHED) begin
        cmd_o.start_ksa = 1'b1;
        ksa_d           = 1'b1;
        state_d         = ST_FILL;
      end else begin
        ksa_d   = 1'b0;
        state_d = ST_RD_I;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ksa_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ksa_q   <= ksa_d;
    end
  end

endmodule

// ----- src/rc4_datapath.sv -----
// ----------------------------------------------------------------------------
// rc4_datapath
// Key registers, permutation memory, indices and the output register.
// ----------------------------------------------------------------------------
module rc4_datapath #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rc4_pkg::KEY_W-1:0]            cfg_wdata_i,
  input  logic [rc4_pkg::BYTE_W-1:0]           data_byte_i,
  input  logic                                 end_of_block_i,
  input  logic                                 out_stall_i,
  input  rc4_pkg::rc4_cmd_t                    cmd_i,
  output rc4_pkg::rc4_status_t                 status_o,
  output logic                                 out_valid_o,
  output logic [rc4_pkg::BYTE_W-1:0]           result_byte_o,
  output logic                                 end_of_block_out_o
);
  import rc4_pkg::*;

  localparam int unsigned KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KLEN_W-1:0] MaxLen = KLEN_W'(MAX_KEY_BYTES);

  // configuration
  logic [KEY_W-1:0]  key_low_q, key_high_q;
  logic [KLEN_W-1:0] key_len_q;

  // generator state
  logic [BYTE_W-1:0] s_mem [S_DEPTH];
  logic [BYTE_W-1:0] rd_q;
  logic [BYTE_W-1:0] i_q, i_d, j_q, j_d;
  logic [KW-1:0]     k_q, k_d;
  logic [BYTE_W-1:0] si_q, sj_q, t_q;
  logic [BYTE_W-1:0] data_q;
  logic              eob_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] result_q;
  logic              eob_out_q;

  logic [BYTE_W-1:0] key_bytes [KEY_SLOTS];
  logic [BYTE_W-1:0] kb;
  logic [KLEN_W-1:0] eff_len;
  logic              k_wrap;
  logic [BYTE_W-1:0] j_new, t_new, raddr, waddr, wdata, ks;
  logic              we;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= KEY_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_LOW:    key_low_q  <= cfg_wdata_i;
        CFG_KEY_HIGH:   key_high_q <= cfg_wdata_i;
        CFG_KEY_LENGTH: key_len_q  <= cfg_wdata_i[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // key byte slots
  always_comb begin
    for (int n = 0; n < KEY_SLOTS / 2; n++) begin
      key_bytes[n]                 = key_low_q[n*BYTE_W +: BYTE_W];
      key_bytes[n + KEY_SLOTS / 2] = key_high_q[n*BYTE_W +: BYTE_W];
    end
  end
  assign kb = key_bytes[KEY_SLOT_W'(k_q)];

  // effective key length, zero reads as one, saturated at the maximum
  assign eff_len = (key_len_q == '0)    ? KLEN_W'(1) :
                   (key_len_q > MaxLen) ? MaxLen : key_len_q;
  assign k_wrap  = (KLEN_W'(k_q) == (eff_len - KLEN_W'(1)));

  // index arithmetic
  assign j_new = j_q + rd_q + (cmd_i.ksa ? kb : '0);
  assign t_new = si_q + rd_q;

  // memory address and write selection
  always_comb begin
    raddr = i_q;
    waddr = i_q;
    wdata = i_q;
    we    = 1'b0;
    if (cmd_i.fill) begin
      we = 1'b1;
    end else if (cmd_i.rd_i) begin
      raddr = cmd_i.ksa ? i_q : i_q + 8'd1;
    end else if (cmd_i.rd_j) begin
      raddr = j_new;
    end else if (cmd_i.wr_i) begin
      raddr = t_new;
      wdata = rd_q;
      we    = 1'b1;
    end else if (cmd_i.wr_j) begin
      raddr = t_q;
      waddr = j_q;
      wdata = si_q;
      we    = 1'b1;
    end
  end

  // permutation memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      s_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= s_mem[raddr];
  end

  // index updates
  always_comb begin
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    if (cmd_i.fill) begin
      i_d = i_q + 8'd1;
    end else if (cmd_i.rd_i && !cmd_i.ksa) begin
      i_d = i_q + 8'd1;
    end else if (cmd_i.rd_j) begin
      j_d = j_new;
      if (cmd_i.ksa) begin
        k_d = k_wrap ? '0 : k_q + KW'(1);
      end
    end else if (cmd_i.wr_j && cmd_i.ksa) begin
      i_d = i_q + 8'd1;
      if (status_o.i_last) begin
        j_d = '0;
      end
    end
    if (cmd_i.start_ksa) begin
      i_d = '0;
      j_d = '0;
      k_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
    end
  end

  // swap operands and pending request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_j) begin
      si_q <= rd_q;
    end
    if (cmd_i.wr_i) begin
      sj_q <= rd_q;
      t_q  <= t_new;
    end
    if (cmd_i.capture) begin
      data_q <= data_byte_i;
      eob_q  <= end_of_block_i;
    end
  end

  // keystream byte with forwarding of the swap writes
  assign ks = (t_q == j_q) ? si_q :
              (t_q == i_q) ? sj_q : rd_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_q  <= data_q ^ ks;
      eob_out_q <= eob_q;
    end
  end

  assign status_o.i_last   = (i_q == 8'hFF);
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign result_byte_o      = result_q;
  assign end_of_block_out_o = eob_out_q;

endmodule

// ----- src/rc4_keystream_cipher_core.sv -----
// ----------------------------------------------------------------------------
// rc4_keystream_cipher_core
// RC4 stream cipher with a key-schedule command and one data byte per
// request. A data byte passes through the read-i, read-j, write-i and
// write-j steps before the next acceptance: its three dependent
// permutation reads and the two swap writes share the single read and
// single write port of the 256-entry permutation memory, and the result
// lands in an output register so the next request is taken while it waits.
// A byte whose result finds that register still full and stalled holds in
// its last step until it drains. A key-schedule request loads the identity,
// runs the same steps for each of the 256 key-scheduling swaps and returns
// to idle before the next request is taken, and gives no result. The key
// is set through the configuration port (key_low, key_high, key_length);
// the user must do so only while the core is idle, which the core does not
// enforce; a data byte must follow at least one key schedule.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher_core #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [rc4_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rc4_pkg::KEY_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [rc4_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                          end_of_block_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rc4_pkg::BYTE_W-1:0]    result_byte_o,
  output logic                          end_of_block_out_o
);
  import rc4_pkg::*;

  rc4_cmd_t    cmd;
  rc4_status_t status;

  // sequencer
  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // memory and arithmetic
  rc4_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .data_byte_i        (data_byte_i),
    .end_of_block_i     (end_of_block_i),
    .out_stall_i        (out_stall_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_valid_o        (out_valid_o),
    .result_byte_o      (result_byte_o),
    .end_of_block_out_o (end_of_block_out_o)
  );

  // a result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("output register overwritten while stalled");

  // at most one memory phase per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.fill, cmd.rd_i, cmd.rd_j, cmd.wr_i, cmd.wr_j}))
    else $error("overlapping memory phases");

  // a key schedule request keeps the input stalled afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (command_i == CMD_KEY_SCHED)) |=> in_stall_o)
    else $error("request accepted during key schedule");

  // key schedule never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ksa |-> !cmd.out_load)
    else $error("result issued by key schedule");

endmodule
